@@ design/cnms_pkg.sv @@
`timescale 1ns / 1ps

package cnms_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int MAG_W      = 11;
    localparam int ANG_W      = 10;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;

    // direction codes
    localparam logic [1:0] DIR_HORZ = 2'd0;
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_VERT = 2'd2;
    localparam logic [1:0] DIR_ANTI = 2'd3;

    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [ANG_W-1:0]  t_ang;
    typedef logic [ADDR_W-1:0] t_addr;

    // one column of the line buffers
    typedef struct packed {
        t_mag upper;
        t_mag middle;
        t_ang angle;
    } t_line_word;

    typedef struct packed {
        logic               last;
        t_mag               mag;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } t_result;

    // fold modulo 180 degrees (360 half degrees) and pick one of four bins
    function automatic logic [1:0] direction_of(input t_ang half_deg);
        t_ang a;
        logic [1:0] dir;
        if (half_deg >= ANG_W'(720)) begin
            a = half_deg - ANG_W'(720);
        end else if (half_deg >= ANG_W'(360)) begin
            a = half_deg - ANG_W'(360);
        end else begin
            a = half_deg;
        end
        if (a < ANG_W'(45) || a >= ANG_W'(315)) begin
            dir = DIR_HORZ;
        end else if (a < ANG_W'(135)) begin
            dir = DIR_DIAG;
        end else if (a < ANG_W'(225)) begin
            dir = DIR_VERT;
        end else begin
            dir = DIR_ANTI;
        end
        return dir;
    endfunction

endpackage

@@ design/canny_non_max_suppression.sv @@
`timescale 1ns / 1ps

// Canny non-maximum suppression over a 3x3 window. Pixels stream in raster order at one
// pixel per clock while the line buffers are not clearing and the output queue has room;
// the result for pixel (r-1, c-1) is formed in the pixel stage holding pixel (r, c) and
// is registered into the output queue, and border pixels produce no result. Rate is set
// by the line buffers: one read and one write per memory per cycle, with a one-deep
// forward around the write. A four-entry output queue lets the input keep flowing while
// results wait. After reset the line buffers clear all 1024 columns, during which
// s_axis_tready stays low; the configuration port works during that time.
module canny_non_max_suppression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // magnitude[10:0], angle_half_deg[20:11], zero pad
    input  logic        s_axis_tuser,   // start_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[11:0], out_col[21:12], edge_magnitude[32:22]
    output logic        m_axis_tlast,   // is_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cnms_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = FP_W + 1;

    // configuration
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [WID_W-1:0] w_w;
    logic [HGT_W-1:0] w_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(500);
            r_height <= HGT_W'(500);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_height <= pwdata[HGT_W-1:0];
            end else begin
                r_width <= pwdata[WID_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-HGT_W){1'b0}}, r_height}
                             : {{(32-WID_W){1'b0}}, r_width};

    always_comb begin
        if (r_width < WID_W'(3)) begin
            w_w = WID_W'(3);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_w = WID_W'(MAX_WIDTH);
        end else begin
            w_w = r_width;
        end
        if (r_height < HGT_W'(3)) begin
            w_h = HGT_W'(3);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            w_h = HGT_W'(MAX_HEIGHT);
        end else begin
            w_h = r_height;
        end
    end

    // input side and position counters
    logic             w_accept;
    logic             w_clr_busy;
    t_mag             w_in_mag;
    t_ang             w_in_ang;
    logic [ROW_W-1:0] r_row, n_row, w_cur_row;
    logic [COL_W-1:0] r_col, n_col, w_cur_col;

    assign w_in_mag  = s_axis_tdata[MAG_W-1:0];
    assign w_in_ang  = s_axis_tdata[MAG_W+ANG_W-1:MAG_W];
    assign w_accept  = s_axis_tvalid & s_axis_tready;
    assign w_cur_row = s_axis_tuser ? '0 : r_row;
    assign w_cur_col = s_axis_tuser ? '0 : r_col;

    always_comb begin
        n_row = w_cur_row;
        n_col = w_cur_col + 1'b1;
        if ({1'b0, w_cur_col} + 1'b1 >= w_w) begin
            n_col = '0;
            if ({1'b0, w_cur_row} + 1'b1 >= w_h) begin
                n_row = '0;
            end else begin
                n_row = w_cur_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // pixel stage: line buffer data arrives here
    logic             r_s1_vld;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    t_mag             r_s1_mag;
    t_ang             r_s1_ang;
    logic             r_byp;
    t_line_word       r_byp_word;
    t_line_word       w_rd_data;
    t_line_word       w_eff;
    t_line_word       w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row   <= w_cur_row;
            r_s1_col   <= w_cur_col;
            r_s1_mag   <= w_in_mag;
            r_s1_ang   <= w_in_ang;
            // the column written this edge is the one being read: forward it
            r_byp      <= r_s1_vld && (r_s1_col == w_cur_col);
            r_byp_word <= w_wr_data;
        end
    end

    assign w_eff = r_byp ? r_byp_word : w_rd_data;

    assign w_wr_data.upper  = w_eff.middle;
    assign w_wr_data.middle = r_s1_mag;
    assign w_wr_data.angle  = r_s1_ang;

    cnms_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (t_addr'(w_cur_col)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (t_addr'(r_s1_col)),
        .i_wr_data (w_wr_data),
        .o_busy    (w_clr_busy)
    );

    // 3x3 window, index row*3+col
    t_mag r_win [0:8];
    t_ang r_ang0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_ang0 <= '0;
        end else if (r_s1_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3+0] <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= w_eff.upper;
            r_win[5] <= w_eff.middle;
            r_win[8] <= r_s1_mag;
            r_ang0   <= w_eff.angle;
        end
    end

    // suppression on the window as it stands after this pixel's shift
    t_mag    w_n0, w_n1, w_center;
    logic    w_res_ok;
    t_result w_res;

    assign w_center = r_win[5];

    always_comb begin
        case (direction_of(r_ang0))
            DIR_HORZ: begin
                w_n0 = w_eff.middle;
                w_n1 = r_win[4];
            end
            DIR_DIAG: begin
                w_n0 = r_win[7];
                w_n1 = w_eff.upper;
            end
            DIR_VERT: begin
                w_n0 = r_win[8];
                w_n1 = r_win[2];
            end
            default: begin
                w_n0 = r_win[1];
                w_n1 = r_s1_mag;
            end
        endcase
    end

    assign w_res_ok = (r_s1_row >= ROW_W'(2)) && (r_s1_col >= COL_W'(2))
                   && ({1'b0, r_s1_row} < w_h) && ({1'b0, r_s1_col} < w_w);

    assign w_res.row  = r_s1_row - 1'b1;
    assign w_res.col  = r_s1_col - 1'b1;
    assign w_res.mag  = (w_center >= w_n0 && w_center >= w_n1) ? w_center : '0;
    assign w_res.last = ({1'b0, r_s1_row} == w_h - 1'b1) && ({1'b0, r_s1_col} == w_w - 1'b1);

    // output queue
    t_result          r_fifo [0:FIFO_DEPTH-1];
    logic [FP_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FC_W-1:0]  r_cnt;
    logic [FC_W:0]    w_inflight;
    logic             w_push, w_pop;
    t_result          w_head;

    assign w_push = r_s1_vld & w_res_ok;
    assign w_pop  = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // take a pixel only when the queue can hold every result still in flight
    assign w_inflight    = {1'b0, r_cnt} + {{FC_W{1'b0}}, r_s1_vld};
    assign s_axis_tready = !w_clr_busy && (w_inflight < (FC_W+1)'(FIFO_DEPTH));

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {7'b0, w_head.mag, w_head.col, w_head.row};
    assign m_axis_tlast  = w_head.last;

    // checks
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (r_cnt < FC_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_clr_busy)
        else $error("pixel taken during line buffer clear");

    a_stage_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_vld)
        else $error("pixel stage lost a transaction");

endmodule

@@ design/cnms_line_buf.sv @@
`timescale 1ns / 1ps

module cnms_line_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  cnms_pkg::t_addr       i_rd_addr,
    output cnms_pkg::t_line_word  o_rd_data,
    input  logic                  i_wr_en,
    input  cnms_pkg::t_addr       i_wr_addr,
    input  cnms_pkg::t_line_word  i_wr_data,
    output logic                  o_busy
);
    import cnms_pkg::*;

    t_mag r_mem_upper  [0:MAX_WIDTH-1];
    t_mag r_mem_middle [0:MAX_WIDTH-1];
    t_ang r_mem_angle  [0:MAX_WIDTH-1];

    logic       r_clr_busy;
    t_addr      r_clr_addr;
    t_addr      w_addr;
    t_line_word w_data;
    logic       w_we;

    // zero every column after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == t_addr'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_we   = r_clr_busy | i_wr_en;
    assign w_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign w_data = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_upper[w_addr]  <= w_data.upper;
            r_mem_middle[w_addr] <= w_data.middle;
            r_mem_angle[w_addr]  <= w_data.angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data.upper  <= r_mem_upper[i_rd_addr];
            o_rd_data.middle <= r_mem_middle[i_rd_addr];
            o_rd_data.angle  <= r_mem_angle[i_rd_addr];
        end
    end

    assign o_busy = r_clr_busy;

endmodule
